// ===== design/dtq_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dtq_pkg: shared types and constants for the delta timer queue
// Operation and status codes, field widths, and the command and status
// groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package dtq_pkg;

	localparam int OP_W     = 2;
	localparam int ID_W     = 4;
	localparam int DELTA_W  = 32;
	localparam int TIME_W   = 64;
	localparam int STATUS_W = 2;

	localparam logic [OP_W-1:0] OP_SPAWN   = 2'd0;
	localparam logic [OP_W-1:0] OP_ADVANCE = 2'd1;
	localparam logic [OP_W-1:0] OP_DELAY   = 2'd2;
	localparam logic [OP_W-1:0] OP_NOP     = 2'd3;

	localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;
	localparam logic [STATUS_W-1:0] ST_NO_CUR = 2'd3;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic                load;       // capture the operation, set up the walk
		logic                spawn;      // push process_id at the head, delta zero
		logic                adv_rd;     // read the head entry
		logic                adv_pop;    // pop the head entry and advance the clock
		logic                adv_empty;  // advance on an empty list
		logic                rd_ptr;     // read the entry under the walk pointer
		logic                step;       // walk past the entry just read
		logic                wr_reduce;  // write back the reduced delta
		logic                rd_src;     // read the entry in front of the shift target
		logic                wr_shift;   // move that entry one place back
		logic                wr_new;     // write the delayed process at its slot
		logic                finish;     // register the result
		logic [STATUS_W-1:0] status;
	} dtq_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            cur_valid;
		logic            full;
		logic            empty;
		logic            walk_end;
		logic            delta_gt;
		logic            shift_done;
	} dtq_stat_t;

endpackage
`default_nettype wire

// ===== design/dtq_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dtq_ctrl: sequencing controller of the delta timer queue
// Decodes each operation and steps the datapath through the list walk and
// the tail shift of a delay insertion.
// ----------------------------------------------------------------------------
module dtq_ctrl
	import dtq_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      start,
	input  wire dtq_stat_t stat,
	output logic           busy,
	output dtq_cmd_t       cmd
);

	localparam logic [2:0] S_IDLE     = 3'd0;
	localparam logic [2:0] S_DECODE   = 3'd1;
	localparam logic [2:0] S_ADV_POP  = 3'd2;
	localparam logic [2:0] S_WALK_RD  = 3'd3;
	localparam logic [2:0] S_WALK_CMP = 3'd4;
	localparam logic [2:0] S_SHIFT_RD = 3'd5;
	localparam logic [2:0] S_SHIFT_WR = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign busy = (state_q != S_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_DECODE;
				end
			end
			S_DECODE: begin
				case (stat.op)
					OP_SPAWN: begin
						cmd.finish = 1'b1;
						state_d    = S_IDLE;
						if (stat.full) begin
							cmd.status = ST_FULL;
						end else begin
							cmd.spawn  = 1'b1;
							cmd.status = ST_OK;
						end
					end
					OP_ADVANCE: begin
						if (stat.empty) begin
							cmd.adv_empty = 1'b1;
							cmd.finish    = 1'b1;
							cmd.status    = ST_EMPTY;
							state_d       = S_IDLE;
						end else begin
							cmd.adv_rd = 1'b1;
							state_d    = S_ADV_POP;
						end
					end
					OP_DELAY: begin
						if (!stat.cur_valid) begin
							cmd.finish = 1'b1;
							cmd.status = ST_NO_CUR;
							state_d    = S_IDLE;
						end else if (stat.full) begin
							cmd.finish = 1'b1;
							cmd.status = ST_FULL;
							state_d    = S_IDLE;
						end else begin
							state_d = S_WALK_RD;
						end
					end
					default: begin
						cmd.finish = 1'b1;
						cmd.status = ST_OK;
						state_d    = S_IDLE;
					end
				endcase
			end
			S_ADV_POP: begin
				cmd.adv_pop = 1'b1;
				cmd.finish  = 1'b1;
				cmd.status  = ST_OK;
				state_d     = S_IDLE;
			end
			S_WALK_RD: begin
				// Past the last live entry the new one simply lands at the tail.
				if (stat.walk_end) begin
					cmd.wr_new = 1'b1;
					cmd.finish = 1'b1;
					cmd.status = ST_OK;
					state_d    = S_IDLE;
				end else begin
					cmd.rd_ptr = 1'b1;
					state_d    = S_WALK_CMP;
				end
			end
			S_WALK_CMP: begin
				if (stat.delta_gt) begin
					cmd.wr_reduce = 1'b1;
					state_d       = S_SHIFT_RD;
				end else begin
					cmd.step = 1'b1;
					state_d  = S_WALK_RD;
				end
			end
			S_SHIFT_RD: begin
				if (stat.shift_done) begin
					cmd.wr_new = 1'b1;
					cmd.finish = 1'b1;
					cmd.status = ST_OK;
					state_d    = S_IDLE;
				end else begin
					cmd.rd_src = 1'b1;
					state_d    = S_SHIFT_WR;
				end
			end
			S_SHIFT_WR: begin
				cmd.wr_shift = 1'b1;
				state_d      = S_SHIFT_RD;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

// ===== design/dtq_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dtq_datapath: list storage, clock and walk registers of the timer queue
// The delta list lives in a circular buffer memory with one write port and
// one registered read port; head pointer and entry count locate it.
// ----------------------------------------------------------------------------
module dtq_datapath
	import dtq_pkg::*;
#(
	parameter int QUEUE_DEPTH = 16
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire dtq_cmd_t            cmd,
	input  wire logic [OP_W-1:0]     operation,
	input  wire logic [ID_W-1:0]     process_id,
	input  wire logic [DELTA_W-1:0]  delay_ticks,
	output dtq_stat_t                stat,
	output logic                     done,
	output logic [STATUS_W-1:0]      status,
	output logic [ID_W-1:0]          run_id,
	output logic [TIME_W-1:0]        now_ticks
);

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int EW = ID_W + DELTA_W;
	localparam logic [AW-1:0] LAST    = AW'(QUEUE_DEPTH - 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);
	localparam logic [CW:0]   DEPTH_X = (CW + 1)'(QUEUE_DEPTH);

	function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
		return (p == LAST) ? '0 : p + 1'b1;
	endfunction

	function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
		return (p == '0) ? LAST : p - 1'b1;
	endfunction

	// Entry storage, no reset: only live entries are ever read.
	logic [EW-1:0]       mem_q [QUEUE_DEPTH];
	logic [EW-1:0]       rd_data_q;
	logic [AW-1:0]       rd_addr;
	logic [AW-1:0]       wr_addr;
	logic [EW-1:0]       wr_data;
	logic                wr_en;

	logic [ID_W-1:0]     rd_id;
	logic [DELTA_W-1:0]  rd_delta;

	logic [OP_W-1:0]     op_q;
	logic [ID_W-1:0]     pid_q;
	logic [DELTA_W-1:0]  rest_q;
	logic [AW-1:0]       ptr_q;
	logic [CW-1:0]       idx_q;
	logic [AW-1:0]       dst_q;
	logic [AW-1:0]       head_q;
	logic [CW-1:0]       count_q;
	logic [TIME_W-1:0]   clock_q;
	logic [ID_W-1:0]     cur_id_q;
	logic                cur_valid_q;
	logic                done_q;
	logic [STATUS_W-1:0] status_q;
	logic [ID_W-1:0]     run_id_q;

	logic [CW:0]         tail_sum;
	logic [AW-1:0]       tail;

	assign rd_id    = rd_data_q[EW-1 -: ID_W];
	assign rd_delta = rd_data_q[DELTA_W-1:0];

	// Physical slot one past the last live entry.
	assign tail_sum = (CW + 1)'(head_q) + (CW + 1)'(count_q);
	assign tail     = (tail_sum >= DEPTH_X) ? AW'(tail_sum - DEPTH_X) : AW'(tail_sum);

	always_comb begin
		rd_addr = '0;
		if (cmd.adv_rd) begin
			rd_addr = head_q;
		end else if (cmd.rd_ptr) begin
			rd_addr = ptr_q;
		end else if (cmd.rd_src) begin
			rd_addr = ptr_dec(dst_q);
		end
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = ptr_q;
		wr_data = {cur_id_q, rest_q};
		if (cmd.spawn) begin
			wr_en   = 1'b1;
			wr_addr = ptr_dec(head_q);
			wr_data = {pid_q, {DELTA_W{1'b0}}};
		end else if (cmd.wr_reduce) begin
			wr_en   = 1'b1;
			wr_data = {rd_id, rd_delta - rest_q};
		end else if (cmd.wr_shift) begin
			wr_en   = 1'b1;
			wr_addr = dst_q;
			wr_data = rd_data_q;
		end else if (cmd.wr_new) begin
			wr_en = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	// Operation and walk registers.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= operation;
			pid_q  <= process_id;
			rest_q <= delay_ticks;
			ptr_q  <= head_q;
			idx_q  <= '0;
			dst_q  <= tail;
		end else begin
			if (cmd.step) begin
				rest_q <= rest_q - rd_delta;
				ptr_q  <= ptr_inc(ptr_q);
				idx_q  <= idx_q + 1'b1;
			end
			if (cmd.wr_shift) begin
				dst_q <= ptr_dec(dst_q);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			count_q     <= '0;
			clock_q     <= '0;
			cur_id_q    <= '0;
			cur_valid_q <= 1'b0;
			done_q      <= 1'b0;
			status_q    <= ST_OK;
			run_id_q    <= '0;
		end else begin
			if (cmd.spawn) begin
				head_q  <= ptr_dec(head_q);
				count_q <= count_q + 1'b1;
			end
			if (cmd.adv_pop) begin
				head_q      <= ptr_inc(head_q);
				count_q     <= count_q - 1'b1;
				cur_id_q    <= rd_id;
				cur_valid_q <= 1'b1;
				clock_q     <= clock_q + TIME_W'(rd_delta);
			end
			if (cmd.adv_empty) begin
				cur_valid_q <= 1'b0;
			end
			if (cmd.wr_new) begin
				count_q     <= count_q + 1'b1;
				cur_valid_q <= 1'b0;
			end
			done_q <= cmd.finish;
			if (cmd.finish) begin
				status_q <= cmd.status;
				run_id_q <= cmd.adv_pop ? rd_id : '0;
			end
		end
	end

	assign stat.op         = op_q;
	assign stat.cur_valid  = cur_valid_q;
	assign stat.full       = (count_q == DEPTH_C);
	assign stat.empty      = (count_q == '0);
	assign stat.walk_end   = (idx_q == count_q);
	assign stat.delta_gt   = (rd_delta > rest_q);
	assign stat.shift_done = (dst_q == ptr_q);

	assign done      = done_q;
	assign status    = status_q;
	assign run_id    = run_id_q;
	assign now_ticks = clock_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_C)
		else $error("entry count exceeds queue depth");

	a_head_bound: assert property (@(posedge clk) disable iff (!arst_n)
		head_q <= LAST)
		else $error("head pointer outside the buffer");

	a_spawn_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.spawn |=> count_q == $past(count_q) + 1'b1)
		else $error("spawn did not add one entry");

	a_pop_current: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.adv_pop |=> cur_valid_q && done_q && run_id_q == cur_id_q)
		else $error("advance did not report the new current process");

	a_fail_run_id: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && status_q != ST_OK |-> run_id_q == '0)
		else $error("failed operation reported a process id");

endmodule
`default_nettype wire

// ===== design/delta_timer_queue_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// delta_timer_queue_core: discrete-event scheduler on a delta list
// Spawns, advances and delays processes; keeps a 64-bit simulated clock.
// ----------------------------------------------------------------------------
// Usage:
//   Drive operation, process_id and delay_ticks and raise start; the command
//   is taken at a clock edge where start is high and busy is low. Each
//   command returns one result: done is high for exactly one cycle while
//   status, run_id and now_ticks hold the result of that transfer. The
//   receiver cannot stall the result; it must take it in that cycle.
//   Spawn, no-op and every error case finish in the decode state; an
//   advance reads the head entry and then pops it. A delay walks the live
//   entries: behind every entry it is written at the tail, in front of one
//   it reduces that entry's delta and shifts it and all behind it one place
//   back first; the walk and the tail shift each read one entry per step
//   through the single registered read port of the list memory. busy falls
//   in the cycle that done is high, so the next command may be taken then.
//   After reset the list is empty, there is no current process and the
//   clock reads zero; no clearing pass is needed.
// ----------------------------------------------------------------------------
module delta_timer_queue_core
	import dtq_pkg::*;
#(
	parameter int QUEUE_DEPTH = 16
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	output logic                     busy,
	input  wire logic [OP_W-1:0]     operation,
	input  wire logic [ID_W-1:0]     process_id,
	input  wire logic [DELTA_W-1:0]  delay_ticks,
	output logic                     done,
	output logic [STATUS_W-1:0]      status,
	output logic [ID_W-1:0]          run_id,
	output logic [TIME_W-1:0]        now_ticks
);

	dtq_cmd_t  cmd;
	dtq_stat_t stat;

	dtq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.busy   (busy),
		.cmd    (cmd)
	);

	dtq_datapath #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.operation   (operation),
		.process_id  (process_id),
		.delay_ticks (delay_ticks),
		.stat        (stat),
		.done        (done),
		.status      (status),
		.run_id      (run_id),
		.now_ticks   (now_ticks)
	);

endmodule
`default_nettype wire
